// ----- design/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted-insert priority queue: the request
// and result payloads, the operation codes and the controller states.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Operation codes carried in the func field of a request.
  typedef enum logic [1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_REVERSE = 2'd1,
    FUNC_DUMP    = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_t;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned COUNT_W = 6;

  // One request item.
  typedef struct packed {
    func_t                      func;
    logic signed [VALUE_W-1:0]  new_value;
  } request_t;

  // One result item.
  typedef struct packed {
    logic signed [VALUE_W-1:0]  entry_value;
    logic                       entry_valid;
    logic                       last;
    logic                       status;
    logic [COUNT_W-1:0]         count;
  } result_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_DUMP = 2'd2
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the accepted request
    logic apply;       // run a single-result operation and emit its result
    logic dump_start;  // clear the dump sweep counter
    logic dump_step;   // rotate the cells once, emitting an entry in the window
  } spq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    func_t func;       // operation of the captured request
    logic  empty;      // no entries held
    logic  full;       // every cell holds an entry
    logic  out_free;   // output register can take a result this cycle
    logic  dump_done;  // dump sweep is on its final rotation
  } spq_sts_t;

endpackage

// ----- design/spq_ctrl.sv -----
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller state machine: accepts a request, then sequences either one
// single-result operation or the full rotation sweep of a dump.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_ready,
  input  spq_pkg::spq_sts_t sts,
  output spq_pkg::spq_cmd_t cmd
);
  import spq_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next    = state;
    cmd           = '0;
    request_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        request_ready = 1'b1;
        if (request_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.func == FUNC_DUMP && !sts.empty) begin
          cmd.dump_start = 1'b1;
          state_next     = ST_DUMP;
        end else if (sts.out_free) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DUMP: begin
        if (sts.out_free) begin
          cmd.dump_step = 1'b1;
          if (sts.dump_done) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/spq_datapath.sv -----
// ----------------------------------------------------------------------------
// spq_datapath
// Row of compare-and-shift cells with head and tail copies, entry count,
// a reversed-order flag, the dump sweep counter and the output register.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int unsigned DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::request_t request,
  input  spq_pkg::spq_cmd_t cmd,
  output spq_pkg::spq_sts_t sts,
  output logic              result_valid,
  input  logic              result_ready,
  output spq_pkg::result_t  result
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = $clog2(DEPTH);

  // Cells: logical order is physical 0..count-1, or count-1..0 when rev is set.
  logic signed [VALUE_W-1:0] cells [DEPTH];
  logic signed [VALUE_W-1:0] head;
  logic signed [VALUE_W-1:0] tail;
  logic [CW-1:0]             count;
  logic                      rev;
  request_t                  op;
  logic [KW-1:0]             k;
  result_t                   out_data;
  logic                      out_valid;

  logic                      out_free;
  logic                      full;
  logic                      empty;
  logic [DEPTH-1:0]          ge;
  logic [DEPTH-1:0]          m_fwd;
  logic [DEPTH-1:0]          g_rev;
  logic [DEPTH-1:0]          beyond;
  logic [DEPTH-1:0]          pre;
  logic [DEPTH-1:0]          suf;
  logic [DEPTH-1:0]          shift_mask;
  logic [DEPTH-1:0]          first_mask;
  logic                      lt_head;
  logic                      at_front;
  logic                      at_tail;
  logic                      none_hit;
  logic                      do_insert;
  logic                      dump_emit;
  logic                      dump_last;
  logic [CW:0]               k_ext;
  logic [CW:0]               n_ext;

  assign out_free = !out_valid || result_ready;
  assign full     = (count >= CW'(DEPTH));
  assign empty    = (count == '0);

  assign sts.func      = op.func;
  assign sts.empty     = empty;
  assign sts.full      = full;
  assign sts.out_free  = out_free;
  assign sts.dump_done = (k == KW'(DEPTH - 1));

  assign result_valid = out_valid;
  assign result       = out_data;

  // Per-cell compares and the insert shift mask (thermometer, set from the
  // insertion point upward in physical order).
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      ge[j]     = !(cells[j] < op.new_value);
      beyond[j] = (CW'(j) >= count);
      m_fwd[j]  = ge[j] && (j >= 1) && !beyond[j];
      g_rev[j]  = ge[j] && ((CW + 1)'(j) + (CW + 1)'(1) < (CW + 1)'(count));
    end
    pre = m_fwd;
    suf = g_rev;
    for (int d = 1; d < DEPTH; d = d * 2) begin
      pre = pre | (pre << d);
      suf = suf | (suf >> d);
    end
    lt_head  = op.new_value < head;
    at_front = empty || lt_head;
    none_hit = rev ? !(|g_rev) : !(|m_fwd);
    at_tail  = empty || (!at_front && none_hit);
    if (at_front) begin
      shift_mask = rev ? beyond : '1;
    end else begin
      shift_mask = rev ? ~suf : (pre | beyond);
    end
    first_mask = shift_mask & ~{shift_mask[DEPTH-2:0], 1'b0};
  end

  assign do_insert = cmd.apply && (op.func == FUNC_INSERT) && !full;

  // Dump sweep: a full rotation of all cells; entries leave from the fixed
  // end cell while the sweep counter is inside the window of stored entries.
  assign k_ext = (CW + 1)'(k);
  assign n_ext = (CW + 1)'(count);
  always_comb begin
    if (rev) begin
      dump_emit = (k_ext + n_ext >= (CW + 1)'(DEPTH));
      dump_last = (k == KW'(DEPTH - 1));
    end else begin
      dump_emit = (k_ext < n_ext);
      dump_last = (k_ext + (CW + 1)'(1) == n_ext);
    end
  end

  // Cell array: insert shift or dump rotation.
  always_ff @(posedge clk) begin
    if (do_insert) begin
      for (int j = 0; j < DEPTH; j++) begin
        if (shift_mask[j]) begin
          cells[j] <= first_mask[j] ? op.new_value : cells[(j + DEPTH - 1) % DEPTH];
        end
      end
    end else if (cmd.dump_step) begin
      for (int j = 0; j < DEPTH; j++) begin
        cells[j] <= rev ? cells[(j + DEPTH - 1) % DEPTH] : cells[(j + 1) % DEPTH];
      end
    end
  end

  // Captured request, head and tail copies, and the sweep counter.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= request;
    end
    if (do_insert) begin
      if (at_front) begin
        head <= op.new_value;
      end
      if (at_tail) begin
        tail <= op.new_value;
      end
    end else if (cmd.apply && op.func == FUNC_REVERSE && count >= CW'(2)) begin
      head <= tail;
      tail <= head;
    end
    if (cmd.dump_start) begin
      k <= '0;
    end else if (cmd.dump_step) begin
      k <= k + KW'(1);
    end
  end

  // Control state: entry count and order flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rev   <= 1'b0;
    end else if (cmd.apply) begin
      case (op.func)
        FUNC_INSERT: begin
          if (!full) begin
            count <= count + CW'(1);
          end
        end
        FUNC_REVERSE: begin
          if (count >= CW'(2)) begin
            rev <= !rev;
          end
        end
        FUNC_CLEAR: begin
          count <= '0;
          rev   <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.apply || (cmd.dump_step && dump_emit)) begin
      out_valid <= 1'b1;
    end else if (result_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      out_data.entry_value <= '0;
      out_data.entry_valid <= 1'b0;
      out_data.last        <= 1'b1;
      out_data.status      <= (op.func == FUNC_INSERT) && full;
      case (op.func)
        FUNC_INSERT: out_data.count <= COUNT_W'(full ? count : count + CW'(1));
        FUNC_CLEAR:  out_data.count <= '0;
        default:     out_data.count <= COUNT_W'(count);
      endcase
    end else if (cmd.dump_step && dump_emit) begin
      out_data.entry_value <= rev ? cells[DEPTH-1] : cells[0];
      out_data.entry_valid <= 1'b1;
      out_data.last        <= dump_last;
      out_data.status      <= 1'b0;
      out_data.count       <= COUNT_W'(count);
    end
  end

endmodule

// ----- design/sorted_insert_priority_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Bounded list of signed values with insert, reverse, dump and clear.
// ----------------------------------------------------------------------------
// Usage: a request carries func and new_value on a valid/ready channel; each
// request yields its results on the result channel, also valid/ready.
// Insert, reverse, clear and a dump of an empty list load their one result
// into the output register from the execute state once the register is free;
// a new request is accepted only after the controller is back in idle.
// Insert compares the value against every cell at once and shifts all cells
// above the insertion point together.
// An insert into a full list is dropped and reported with status set.
// Dump sweeps the cells through one full rotation, emitting the count stored
// entries and returning the cells to their original places.
// Reverse only flips an order flag and swaps the head and tail copies.
// A result waits in the output register while the receiver stalls; each
// single-result operation and each rotation step of a dump holds until the
// register is free.
// Reset empties the list and drops any pending result.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue #(
  parameter int unsigned DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_ready,
  input  spq_pkg::request_t request,
  output logic              result_valid,
  input  logic              result_ready,
  output spq_pkg::result_t  result
);
  import spq_pkg::*;

  spq_cmd_t cmd;
  spq_sts_t sts;

  spq_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  spq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .cmd          (cmd),
    .sts          (sts),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // A dumped entry never carries the dropped-insert flag.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.entry_valid && result.status))
    else $error("dumped entry flagged as dropped insert");

  // An insert is dropped only when the list is full.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.apply && sts.func == FUNC_INSERT && !sts.full) |=> !result.status)
    else $error("insert dropped while list had room");

  // Results that carry no entry always close their request.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.entry_valid) |-> result.last)
    else $error("non-entry result without last");

  // The controller never issues a single-result command during a sweep step, nor a load together with either.
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.apply && cmd.dump_step) && !(cmd.load && (cmd.apply || cmd.dump_step)))
    else $error("conflicting datapath commands");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sorted-insert priority queue. Requests are
// driven through the request channel with random gaps while the result
// channel stalls at random. A scoreboard keeps its own copy of the list,
// works out the results that each accepted request should produce and checks
// every result field by field, oldest first.
// ----------------------------------------------------------------------------
module tb_top;
  import spq_pkg::*;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned CLK_PERIOD = 8;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RANDOM_REQUESTS = 450;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;

  typedef logic signed [VALUE_W-1:0] value_t;

  // Scoreboard: list model plus the queue of results still owed by the block.
  class sorted_list_scoreboard;
    value_t      held_values[$];
    result_t     due_results[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction

    // The count field always reflects the list after the operation.
    function void add_due(value_t value, logic valid, logic last_flag, logic drop_flag);
      result_t r;
      r.entry_value = value;
      r.entry_valid = valid;
      r.last        = last_flag;
      r.status      = drop_flag;
      r.count       = COUNT_W'(held_values.size());
      due_results.push_back(r);
    endfunction

    // Apply one accepted request to the list model and queue its results.
    function void note_request(request_t req);
      int unsigned n;
      int unsigned pos;
      value_t      swap;
      n = held_values.size();
      case (req.func)
        FUNC_INSERT: begin
          if (n >= DEPTH) begin
            // A full list drops the value and flags it.
            add_due('0, 1'b0, 1'b1, 1'b1);
          end else begin
            // Front when empty or below the head, else before the first
            // later entry that is not smaller.
            pos = 0;
            if (n != 0 && !(req.new_value < held_values[0])) begin
              pos = 1;
              while (pos < n && held_values[pos] < req.new_value) pos++;
            end
            held_values.insert(pos, req.new_value);
            add_due('0, 1'b0, 1'b1, 1'b0);
          end
        end
        FUNC_REVERSE: begin
          for (int i = 0; i < n / 2; i++) begin
            swap = held_values[i];
            held_values[i] = held_values[n - 1 - i];
            held_values[n - 1 - i] = swap;
          end
          add_due('0, 1'b0, 1'b1, 1'b0);
        end
        FUNC_DUMP: begin
          if (n == 0) begin
            add_due('0, 1'b0, 1'b1, 1'b0);
          end else begin
            for (int i = 0; i < n; i++) begin
              add_due(held_values[i], 1'b1, (i == n - 1), 1'b0);
            end
          end
        end
        default: begin
          held_values.delete();
          add_due('0, 1'b0, 1'b1, 1'b0);
        end
      endcase
    endfunction

    function void compare_field(string name, logic signed [VALUE_W:0] want,
                                logic signed [VALUE_W:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // Check one accepted result against the oldest owed result.
    function void check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing owed: entry_value %0d, count %0d",
               got.entry_value, got.count);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      compare_field("entry_value", want.entry_value, got.entry_value);
      compare_field("entry_valid", want.entry_valid, got.entry_valid);
      compare_field("last", want.last, got.last);
      compare_field("status", want.status, got.status);
      compare_field("count", want.count, got.count);
    endfunction
  endclass

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     request_valid = 1'b0;
  logic     request_ready;
  request_t request = '0;
  logic     result_valid;
  logic     result_ready = 1'b0;
  result_t  result;

  sorted_list_scoreboard sb;
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  int unsigned ready_run = 0;
  int unsigned ready_roll;
  bit          calm = 1'b0;

  sorted_insert_priority_queue #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_ready(request_ready),
    .request      (request),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Receiver: runs of ready and stall of random length, long ones now and then; steady ready while calm.
  always @(posedge clk) begin
    if (ready_run > 0) begin
      ready_run <= ready_run - 1;
    end else if (calm) begin
      result_ready <= 1'b1;
      ready_run <= 10;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 55) begin
        result_ready <= 1'b1;
        ready_run <= $urandom_range(0, 6);
      end else if (ready_roll < 65) begin
        result_ready <= 1'b1;
        ready_run <= $urandom_range(20, 80);
      end else if (ready_roll < 95) begin
        result_ready <= 1'b0;
        ready_run <= $urandom_range(0, 3);
      end else begin
        result_ready <= 1'b0;
        ready_run <= $urandom_range(10, 40);
      end
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      sb.check_result(result);
    end
  end

  // Count cycles in which neither channel moves anything.
  always @(posedge clk) begin
    if (rst || (request_valid && request_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog.
  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic request_t make_request(func_t f, value_t v);
    request_t req;
    req.func = f;
    req.new_value = v;
    return req;
  endfunction

  // Mostly full-range values, with small values for duplicates and extremes.
  function automatic value_t pick_value();
    int unsigned r;
    int          near_zero;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom;
    if (r < 85) begin
      near_zero = $urandom_range(0, 16);
      return near_zero - 8;
    end
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_fffe;
      3: return 32'sh8000_0001;
      4: return 32'sh0000_0000;
      default: return 32'shffff_ffff;
    endcase
  endfunction

  function automatic func_t pick_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return FUNC_INSERT;
    if (r < 76) return FUNC_REVERSE;
    if (r < 96) return FUNC_DUMP;
    return FUNC_CLEAR;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // Present one request, hold it until accepted, then maybe idle a while.
  task automatic send_request(input request_t req);
    int unsigned gap;
    request_valid <= 1'b1;
    request <= req;
    do @(posedge clk); while (!request_ready);
    sb.note_request(req);
    sent++;
    gap = pick_gap();
    if (gap != 0) begin
      request_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off new requests until every owed result has come back.
  task automatic drain_pause();
    request_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  initial begin
    int unsigned goal;
    int unsigned len;
    int unsigned extra;
    sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, single entry, extremes, duplicates, insert after
    // a reversal, dumps and clears.
    send_request(make_request(FUNC_DUMP, 32'sh1234_5678));
    send_request(make_request(FUNC_REVERSE, 32'sh8000_0000));
    send_request(make_request(FUNC_CLEAR, 32'sh7fff_ffff));
    send_request(make_request(FUNC_INSERT, 32'sh0000_0000));
    send_request(make_request(FUNC_REVERSE, 32'shffff_ffff));
    send_request(make_request(FUNC_DUMP, 32'sh0000_0000));
    send_request(make_request(FUNC_INSERT, 32'sh7fff_ffff));
    send_request(make_request(FUNC_INSERT, 32'sh8000_0000));
    send_request(make_request(FUNC_INSERT, 32'shffff_ffff));
    send_request(make_request(FUNC_INSERT, 32'sh0000_0000));
    send_request(make_request(FUNC_INSERT, 32'sh0000_0001));
    send_request(make_request(FUNC_DUMP, 32'shaaaa_5555));
    send_request(make_request(FUNC_REVERSE, 32'sh5555_aaaa));
    send_request(make_request(FUNC_INSERT, 32'sh0000_0005));
    send_request(make_request(FUNC_INSERT, 32'sh7fff_ffff));
    send_request(make_request(FUNC_INSERT, 32'shffff_fffe));
    send_request(make_request(FUNC_INSERT, 32'sh8000_0000));
    send_request(make_request(FUNC_DUMP, 32'shffff_ffff));
    send_request(make_request(FUNC_CLEAR, 32'sh0000_0000));
    send_request(make_request(FUNC_DUMP, 32'sh0000_0000));
    send_request(make_request(FUNC_INSERT, 32'sh8000_0000));
    send_request(make_request(FUNC_DUMP, 32'sh7fff_ffff));
    drain_pause();

    // Random bursts: fill-to-overflow runs, duplicate-heavy runs and mixes.
    goal = sent + RANDOM_REQUESTS;
    while (sent < goal) begin
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) drain_pause();
      case ($urandom_range(0, 3))
        0: begin
          send_request(make_request(FUNC_CLEAR, pick_value()));
          extra = $urandom_range(1, 4);
          for (int i = 0; i < DEPTH + extra; i++) begin
            if ($urandom_range(0, 9) == 0) begin
              send_request(make_request(FUNC_REVERSE, pick_value()));
            end
            send_request(make_request(FUNC_INSERT, pick_value()));
          end
          send_request(make_request(FUNC_DUMP, pick_value()));
        end
        1: begin
          len = $urandom_range(6, 20);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 4) == 0) begin
              send_request(make_request(FUNC_REVERSE, pick_value()));
            end else begin
              send_request(make_request(FUNC_INSERT, $urandom_range(0, 4) - 2));
            end
          end
          send_request(make_request(FUNC_DUMP, pick_value()));
        end
        default: begin
          len = $urandom_range(8, 30);
          for (int i = 0; i < len; i++) begin
            send_request(make_request(pick_func(), pick_value()));
          end
        end
      endcase
    end

    // Let everything owed come back, then allow the block to settle.
    calm = 1'b0;
    request_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/spq_pkg.sv
design/spq_ctrl.sv
design/spq_datapath.sv
design/sorted_insert_priority_queue.sv
dv/tb_top.sv
